[rtl/art_pkg.sv]
`timescale 1ns / 1ps
// art_pkg: shared types, opcodes and helpers for the aging request table.
// Used by art_cell, aging_request_table and art_checker; no dependencies.
package art_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [31:0] TIMEOUT_RESET = 32'd600000;

  // Operation codes
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_RM_KEY = 3'd2;
  localparam logic [2:0] OP_RM_IDX = 3'd3;
  localparam logic [2:0] OP_EXPIRE = 3'd4;
  localparam logic [2:0] OP_LOOKUP = 3'd5;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] name_key;
    logic [15:0] job;
    logic [15:0] level;
    logic [3:0]  entry_index;
    logic [31:0] now_ms;
  } art_cmd_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  found_index;
    logic [15:0] found_job;
    logic [15:0] found_level;
    logic [31:0] found_time;
    logic [4:0]  entry_count;
    logic [4:0]  removed_count;
  } art_result_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] job;
    logic [15:0] level;
    logic [31:0] time_ms;
  } art_entry_t;

  // Row-wide control from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic load_mark;
    logic shift_en;
  } art_cell_ctrl_t;

  // Fold letters to lower case and zero every byte after the terminator,
  // so two names compare equal exactly when their normal forms match.
  function automatic logic [63:0] norm_key(input logic [63:0] k);
    logic [63:0] r;
    logic        ended;
    logic [7:0]  c;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      c = k[8*i +: 8];
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
        c = c + CASE_OFFSET;
      end
      if (!ended) begin
        r[8*i +: 8] = c;
      end
      if (c == 8'd0) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

[rtl/art_cell.sv]
`timescale 1ns / 1ps
// art_cell: one slot of the table row; holds an entry, its valid and mark bits.
// Depends on art_pkg. Shifts in its upper neighbor's content while compacting.
module art_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  art_pkg::art_cell_ctrl_t ctrl,
  input  logic                    mark_load,
  input  logic                    wr,
  input  art_pkg::art_entry_t     new_entry,
  input  logic [63:0]             cmp_key,
  input  logic [31:0]             now_ms,
  input  logic [31:0]             timeout_ms,
  input  logic                    carry_in,
  output logic                    carry_out,
  input  art_pkg::art_entry_t     up_entry,
  input  logic                    up_valid,
  input  logic                    up_mark,
  output art_pkg::art_entry_t     entry,
  output logic                    valid,
  output logic                    mark,
  output logic                    match,
  output logic                    expired
);
  import art_pkg::*;

  logic [31:0] expiry;
  logic        shift_here;

  // Shift when this cell or any cell below it is marked
  assign shift_here = carry_in | mark;
  assign carry_out  = shift_here;

  assign expiry  = entry.time_ms + timeout_ms;
  assign match   = valid & (entry.key == cmp_key);
  assign expired = valid & (expiry <= now_ms);

  // Control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
      mark  <= 1'b0;
    end else if (ctrl.load_mark) begin
      mark <= mark_load;
    end else if (ctrl.shift_en && shift_here) begin
      valid <= up_valid;
      mark  <= up_mark;
    end else if (wr) begin
      valid <= 1'b1;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      entry <= '0;
    end else if (ctrl.load_mark) begin
      entry <= entry;
    end else if (ctrl.shift_en && shift_here) begin
      entry <= up_entry;
    end else if (wr) begin
      entry <= new_entry;
    end
  end

endmodule

[rtl/aging_request_table.sv]
`timescale 1ns / 1ps
// aging_request_table: age-ordered table of CAPACITY request entries in a row of cells.
// Clear and lookup go from the mark state straight to report; removals close each gap
// (k entries removed, one per cycle by the compaction shift), and add may first evict the oldest.
// Expire marks every expired entry and compacts them away. One transaction at a time; start is taken
// again in the cycle done is high. Synchronous reset empties the table, timeout 600000.
module aging_request_table (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  art_pkg::art_cmd_t    cmd,
  output logic                 done,
  output art_pkg::art_result_t result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);
  import art_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MARK   = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_REPORT = 3'd4;

  logic [2:0]       state;
  logic [2:0]       op_r;
  logic [63:0]      key_r;
  logic [15:0]      job_r;
  logic [15:0]      level_r;
  logic [3:0]       idx_r;
  logic [31:0]      now_r;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] removed;
  logic             ok_r;
  logic             evict_done;
  logic [3:0]       f_index;
  logic [15:0]      f_job;
  logic [15:0]      f_level;
  logic [31:0]      f_time;
  logic [31:0]      timeout_ms;

  art_cell_ctrl_t      ctrl;
  art_entry_t          new_entry;
  art_entry_t          cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_mark;
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] cell_expired;
  logic [CAPACITY-1:0] mark_vec;
  logic [CAPACITY-1:0] wr_vec;
  logic [CAPACITY:0]   carry;
  logic [IDX_W-1:0]    hit_idx;
  logic                hit;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] idx_vec;
  logic                any_mark;
  logic                full;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign any_mark  = |cell_mark;
  assign full      = (count == CNT_W'(CAPACITY));
  assign carry[0]  = 1'b0;

  assign new_entry.key     = key_r;
  assign new_entry.job     = job_r;
  assign new_entry.level   = level_r;
  assign new_entry.time_ms = now_r;

  // Row of cells; the top cell shifts in an empty slot
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    art_entry_t up_entry;
    logic       up_valid;
    logic       up_mark;
    if (g == CAPACITY - 1) begin : g_top
      assign up_entry = '0;
      assign up_valid = 1'b0;
      assign up_mark  = 1'b0;
    end else begin : g_mid
      assign up_entry = cell_entry[g+1];
      assign up_valid = cell_valid[g+1];
      assign up_mark  = cell_mark[g+1];
    end
    art_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .mark_load  (mark_vec[g]),
      .wr         (wr_vec[g]),
      .new_entry  (new_entry),
      .cmp_key    (key_r),
      .now_ms     (now_r),
      .timeout_ms (timeout_ms),
      .carry_in   (carry[g]),
      .carry_out  (carry[g+1]),
      .up_entry   (up_entry),
      .up_valid   (up_valid),
      .up_mark    (up_mark),
      .entry      (cell_entry[g]),
      .valid      (cell_valid[g]),
      .mark       (cell_mark[g]),
      .match      (cell_match[g]),
      .expired    (cell_expired[g])
    );
  end

  // Pick the newest matching entry
  always_comb begin
    hit_idx = '0;
    hit     = 1'b0;
    hit_vec = '0;
    idx_vec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_match[i]) begin
        hit_idx = IDX_W'(i);
        hit     = 1'b1;
      end
      idx_vec[i] = cell_valid[i] & (int'(idx_r) == i);
    end
    if (hit) begin
      hit_vec[hit_idx] = 1'b1;
    end
  end

  // Drive the cell row
  always_comb begin
    ctrl     = '0;
    mark_vec = '0;
    wr_vec   = '0;
    unique case (state)
      ST_MARK: begin
        unique case (op_r)
          OP_CLEAR: begin
            ctrl.clear = 1'b1;
          end
          OP_ADD, OP_RM_KEY: begin
            ctrl.load_mark = 1'b1;
            mark_vec       = hit_vec;
          end
          OP_RM_IDX: begin
            ctrl.load_mark = 1'b1;
            mark_vec       = idx_vec;
          end
          OP_EXPIRE: begin
            ctrl.load_mark = 1'b1;
            mark_vec       = cell_expired;
          end
          default: begin
          end
        endcase
      end
      ST_SHIFT: begin
        if (any_mark) begin
          ctrl.shift_en = 1'b1;
        end else if (op_r == OP_ADD && !evict_done && full) begin
          ctrl.load_mark = 1'b1;
          mark_vec[0]    = 1'b1;
        end
      end
      ST_APPEND: begin
        wr_vec[count[IDX_W-1:0]] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_REPORT);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MARK;
          end
        end
        ST_MARK: begin
          unique case (op_r)
            OP_CLEAR: begin
              count <= '0;
              state <= ST_REPORT;
            end
            OP_ADD, OP_RM_KEY, OP_RM_IDX, OP_EXPIRE: begin
              state <= ST_SHIFT;
            end
            default: begin
              state <= ST_REPORT;
            end
          endcase
        end
        ST_SHIFT: begin
          if (any_mark) begin
            count <= count - CNT_W'(1);
          end else if (op_r == OP_ADD) begin
            if (evict_done || !full) begin
              state <= ST_APPEND;
            end
          end else begin
            state <= ST_REPORT;
          end
        end
        ST_APPEND: begin
          count <= count + CNT_W'(1);
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Transaction payload and status; no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_r       <= cmd.op;
      key_r      <= norm_key(cmd.name_key);
      job_r      <= cmd.job;
      level_r    <= cmd.level;
      idx_r      <= cmd.entry_index;
      now_r      <= cmd.now_ms;
      removed    <= '0;
      ok_r       <= 1'b0;
      evict_done <= 1'b0;
      f_index    <= '0;
      f_job      <= '0;
      f_level    <= '0;
      f_time     <= '0;
    end
    if (state == ST_MARK) begin
      case (op_r)
        OP_CLEAR: begin
          ok_r    <= 1'b1;
          removed <= count;
        end
        OP_ADD, OP_EXPIRE: begin
          ok_r <= 1'b1;
        end
        OP_RM_KEY: begin
          ok_r <= hit;
        end
        OP_RM_IDX: begin
          ok_r <= |idx_vec;
        end
        OP_LOOKUP: begin
          ok_r <= hit;
          if (hit) begin
            f_index <= 4'(hit_idx);
            f_job   <= cell_entry[hit_idx].job;
            f_level <= cell_entry[hit_idx].level;
            f_time  <= cell_entry[hit_idx].time_ms;
          end
        end
        default: begin
        end
      endcase
    end
    if (state == ST_SHIFT) begin
      if (any_mark) begin
        removed <= removed + CNT_W'(1);
      end else if (op_r == OP_ADD) begin
        evict_done <= 1'b1;
      end
    end
    if (state == ST_REPORT) begin
      result.ok            <= ok_r;
      result.found_index   <= f_index;
      result.found_job     <= f_job;
      result.found_level   <= f_level;
      result.found_time    <= f_time;
      result.entry_count   <= 5'(count);
      result.removed_count <= 5'(removed);
    end
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ms <= cfg_data;
    end
  end

endmodule

[rtl/art_checker.sv]
`timescale 1ns / 1ps
// art_checker: port-level checks on the aging request table transaction flow.
// Depends on art_pkg; bound to aging_request_table at the end of this file.
module art_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input art_pkg::art_result_t result
);
  import art_pkg::*;

  // Accepted transaction occupies the block on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted transaction did not occupy the block");

  // A result is only reported once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("done outside the end of a transaction");

  // Entry count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_count <= 5'(CAPACITY)))
    else $error("entry count beyond capacity");

  // A failed operation removes nothing
  a_fail_no_remove: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.removed_count == 5'd0))
    else $error("failed operation reported removals");

endmodule

bind aging_request_table art_checker u_art_checker (.*);

[dv/aging_request_table_test.sv]
`timescale 1ns / 1ps
// aging_request_table_test: self-checking testbench for the aging request table.
// Depends on art_pkg and aging_request_table; predicts every result from its own table copy.
module aging_request_table_test;
  import art_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int KEY_POOL     = 24;
  localparam int PRINT_CAP    = 100;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  art_cmd_t    cmd       = '0;
  logic        done;
  art_result_t result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  aging_request_table u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted table contents, oldest entry at position 0
  logic [63:0] tbl_key   [CAPACITY];
  logic [15:0] tbl_job   [CAPACITY];
  logic [15:0] tbl_level [CAPACITY];
  logic [31:0] tbl_time  [CAPACITY];
  int          tbl_used;
  logic [31:0] model_timeout;

  art_cmd_t    pending_cmds[$];
  art_result_t expected_results[$];
  logic [63:0] key_pool[KEY_POOL];
  logic [31:0] sim_ms;
  int          total_queued  = 0;
  int          results_seen  = 0;
  int          fail_count    = 0;
  int          gap_left      = 0;
  int          calm_left     = 0;
  int          cycle_count   = 0;

  function automatic void table_clear();
    for (int i = 0; i < CAPACITY; i++) begin
      tbl_key[i]   = '0;
      tbl_job[i]   = '0;
      tbl_level[i] = '0;
      tbl_time[i]  = '0;
    end
    tbl_used = 0;
  endfunction

  function automatic logic [7:0] fold_byte(logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  // Compare as zero-terminated strings, letter case ignored
  function automatic bit names_match(logic [63:0] a, logic [63:0] b);
    logic [7:0] ca;
    logic [7:0] cb;
    for (int i = 0; i < 8; i++) begin
      ca = fold_byte(a[8*i +: 8]);
      cb = fold_byte(b[8*i +: 8]);
      if (ca != cb) begin
        return 1'b0;
      end
      if (ca == 8'd0) begin
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // Search from the newest entry down; -1 when absent
  function automatic int newest_match(logic [63:0] key);
    for (int i = tbl_used - 1; i >= 0; i--) begin
      if (names_match(tbl_key[i], key)) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Close the gap, then zero the freed last slot
  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < tbl_used; i++) begin
      tbl_key[i]   = tbl_key[i + 1];
      tbl_job[i]   = tbl_job[i + 1];
      tbl_level[i] = tbl_level[i + 1];
      tbl_time[i]  = tbl_time[i + 1];
    end
    tbl_used--;
    tbl_key[tbl_used]   = '0;
    tbl_job[tbl_used]   = '0;
    tbl_level[tbl_used] = '0;
    tbl_time[tbl_used]  = '0;
  endfunction

  // Apply one transaction to the predicted table and return its result
  function automatic art_result_t table_apply(art_cmd_t c);
    art_result_t r;
    int          p;
    int          removed;
    int          k;
    logic [31:0] deadline;
    r       = '0;
    removed = 0;
    case (c.op)
      OP_CLEAR: begin
        removed = tbl_used;
        table_clear();
        r.ok = 1'b1;
      end
      OP_ADD: begin
        p = newest_match(c.name_key);
        if (p >= 0) begin
          drop_entry(p);
          removed++;
        end
        if (tbl_used >= CAPACITY) begin
          drop_entry(0);
          removed++;
        end
        tbl_key[tbl_used]   = c.name_key;
        tbl_job[tbl_used]   = c.job;
        tbl_level[tbl_used] = c.level;
        tbl_time[tbl_used]  = c.now_ms;
        tbl_used++;
        r.ok = 1'b1;
      end
      OP_RM_KEY: begin
        p = newest_match(c.name_key);
        if (p >= 0) begin
          drop_entry(p);
          r.ok    = 1'b1;
          removed = 1;
        end
      end
      OP_RM_IDX: begin
        if (int'(c.entry_index) < tbl_used) begin
          drop_entry(int'(c.entry_index));
          r.ok    = 1'b1;
          removed = 1;
        end
      end
      OP_EXPIRE: begin
        k = 0;
        while (k < tbl_used) begin
          deadline = tbl_time[k] + model_timeout;
          if (deadline <= c.now_ms) begin
            drop_entry(k);
            removed++;
          end else begin
            k++;
          end
        end
        r.ok = 1'b1;
      end
      OP_LOOKUP: begin
        p = newest_match(c.name_key);
        if (p >= 0) begin
          r.ok          = 1'b1;
          r.found_index = 4'(p);
          r.found_job   = tbl_job[p];
          r.found_level = tbl_level[p];
          r.found_time  = tbl_time[p];
        end
      end
      default: begin
      end
    endcase
    r.entry_count   = 5'(tbl_used);
    r.removed_count = 5'(removed);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    fail_count++;
  endtask

  task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", fname, got, want));
    end
  endtask

  // Mostly short gaps, a few long ones, and stretches with none
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Issue queued commands; predict each transaction when it is accepted
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(table_apply(cmd));
      end
      // hold start while the block is busy
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() > 0) begin
          start    <= 1'b1;
          cmd      <= pending_cmds.pop_front();
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Compare every strobed result with the oldest prediction
  always @(posedge clk) begin : result_monitor
    art_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, entry_count %0d", result.entry_count));
      end else begin
        want = expected_results.pop_front();
        check_field("ok", result.ok, want.ok);
        check_field("found_index", result.found_index, want.found_index);
        check_field("found_job", result.found_job, want.found_job);
        check_field("found_level", result.found_level, want.found_level);
        check_field("found_time", result.found_time, want.found_time);
        check_field("entry_count", result.entry_count, want.entry_count);
        check_field("removed_count", result.removed_count, want.removed_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("aging_request_table test failed");
      $finish;
    end
  end

  function automatic logic [63:0] str_key(string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) begin
      k[8*i +: 8] = s[i];
    end
    return k;
  endfunction

  // Name bytes: letters of both cases, digits, bytes next to the letter ranges, high bytes
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(0, 25)) + ((r < 3) ? 8'h41 : 8'h61);
    if (r == 6) return 8'h30 + 8'($urandom_range(0, 9));
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0:       return 8'h40;
        1:       return 8'h5B;
        2:       return 8'h60;
        default: return 8'h7B;
      endcase
    end
    if (r == 8) return 8'($urandom_range(128, 255));
    return 8'h61 + 8'($urandom_range(0, 5));
  endfunction

  // Randomize letter case and sometimes fill the bytes past the terminator
  function automatic logic [63:0] vary_key(logic [63:0] k);
    logic [63:0] v;
    logic [7:0]  c;
    bit          ended;
    bit          junk;
    v     = k;
    ended = 1'b0;
    junk  = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 8; i++) begin
      c = v[8*i +: 8];
      if (ended) begin
        if (junk) v[8*i +: 8] = 8'($urandom);
      end else if (c == 8'd0) begin
        ended = 1'b1;
      end else if (fold_byte(c) >= 8'h61 && fold_byte(c) <= 8'h7A && $urandom_range(0, 1)) begin
        v[8*i +: 8] = c ^ CASE_OFFSET;
      end
    end
    return v;
  endfunction

  task automatic queue_cmd(logic [2:0] op, logic [63:0] key, logic [15:0] job,
                           logic [15:0] level, logic [3:0] idx, logic [31:0] now);
    art_cmd_t c;
    c.op          = op;
    c.name_key    = key;
    c.job         = job;
    c.level       = level;
    c.entry_index = idx;
    c.now_ms      = now;
    pending_cmds.push_back(c);
    total_queued++;
  endtask

  // Mostly well-formed traffic on a small key pool, with some noise
  task automatic queue_random(int n, int max_step);
    int          r;
    logic [63:0] pk;
    logic [2:0]  op;
    for (int i = 0; i < n; i++) begin
      r      = $urandom_range(0, 99);
      sim_ms = sim_ms + 32'($urandom_range(0, max_step));
      pk     = vary_key(key_pool[$urandom_range(0, KEY_POOL - 1)]);
      if (r < 45) begin
        op = OP_ADD;
      end else if (r < 62) begin
        op = OP_LOOKUP;
        if (r >= 59) pk = {$urandom, $urandom};
      end else if (r < 70) begin
        op = OP_RM_KEY;
      end else if (r < 78) begin
        op = OP_RM_IDX;
      end else if (r < 88) begin
        op = OP_EXPIRE;
      end else if (r < 89) begin
        op = OP_CLEAR;
      end else if (r < 92) begin
        op = 3'($urandom_range(6, 7));
      end else begin
        queue_cmd(3'($urandom_range(0, 7)), {$urandom, $urandom}, 16'($urandom),
                  16'($urandom), 4'($urandom), 32'($urandom));
        continue;
      end
      queue_cmd(op, pk, 16'($urandom), 16'($urandom), 4'($urandom), sim_ms);
    end
  endtask

  task automatic wait_all_done();
    while (results_seen != total_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    model_timeout = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    table_clear();
    model_timeout = TIMEOUT_RESET;
    sim_ms        = '0;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = '0;
      for (int b = 0; b < $urandom_range(1, 8); b++) begin
        key_pool[i][8*b +: 8] = pick_char();
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty table: every search misses, expire is a no-op
    queue_cmd(OP_LOOKUP, '0, '0, '0, 4'd0, '0);
    queue_cmd(OP_RM_IDX, '0, '0, '0, 4'd0, '0);
    queue_cmd(OP_RM_KEY, str_key("ghost"), '0, '0, 4'd0, '0);
    queue_cmd(OP_EXPIRE, '0, '0, '0, 4'd0, 32'd0);
    // Duplicate key in other case replaces the first entry
    queue_cmd(OP_ADD, str_key("Alpha"), 16'hFFFF, 16'h0000, 4'd0, 32'd0);
    queue_cmd(OP_ADD, str_key("ALPHA"), 16'h0000, 16'hFFFF, 4'hF, 32'd100);
    // Bytes past the terminator do not take part in the compare
    queue_cmd(OP_LOOKUP, str_key("alpha") | 64'hCDEF_0000_0000_0000, '0, '0, 4'd0, '0);
    queue_cmd(OP_ADD, 64'd0, 16'h1234, 16'h5678, 4'd0, 32'd200);
    queue_cmd(OP_ADD, '1, 16'hFFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    // Fill the table; the last add evicts the oldest
    for (int i = 0; i < 14; i++) begin
      queue_cmd(OP_ADD, str_key($sformatf("k%02d", i)), 16'(i), 16'(i * 3), 4'd0,
                32'(1000 + i));
    end
    queue_cmd(OP_RM_IDX, '0, '0, '0, 4'd15, '0);
    queue_cmd(OP_RM_IDX, '0, '0, '0, 4'd15, '0);
    queue_cmd(OP_LOOKUP, str_key("K05"), '0, '0, 4'd0, '0);
    queue_cmd(3'd6, str_key("k06"), '0, '0, 4'd0, '0);
    // Wrapped deadline of the all-ones entry falls due as well
    queue_cmd(OP_EXPIRE, '0, '0, '0, 4'd0, 32'd700000);
    queue_cmd(OP_CLEAR, '0, '0, '0, 4'd0, '0);
    wait_all_done();

    write_timeout(32'd0);
    queue_random(150, 2000);
    wait_all_done();

    // Time wraps past zero during this phase
    write_timeout(32'hFFFF_FFFF);
    sim_ms = 32'hFFFF_F000;
    queue_random(150, 64);
    wait_all_done();

    write_timeout(32'd1000);
    queue_random(250, 300);
    wait_all_done();

    write_timeout(32'd50);
    queue_random(150, 30);
    wait_all_done();

    // Long timeout: the table fills and evicts
    write_timeout(TIMEOUT_RESET);
    queue_random(250, 100);
    wait_all_done();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("aging_request_table test passed");
    end else begin
      $display("aging_request_table test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/art_pkg.sv
rtl/art_cell.sv
rtl/aging_request_table.sv
rtl/art_checker.sv
dv/aging_request_table_test.sv
